>>> hw/rtl/crfs_pkg.sv
package crfs_pkg;

    // default fraction width of the ring positions
    localparam int FRACTION_BITS_DEF = 16;

    // datapath widths
    localparam int NUM_W      = 36;
    localparam int STEP_W     = 26;
    localparam int TSEC_W     = 16;
    localparam int MIN_MS_W   = 22;
    localparam int HOUR_MS_W  = 27;
    localparam int DAY_MS_W   = 32;
    localparam int MONTH_MS_W = 32;

    // period lengths in milliseconds
    localparam logic [TSEC_W-1:0]     MS_PER_SECOND = 16'd1000;
    localparam logic [MIN_MS_W-1:0]   MS_PER_MINUTE = 22'd60000;
    localparam logic [HOUR_MS_W-1:0]  MS_PER_HOUR   = 27'd3600000;
    localparam logic [DAY_MS_W-1:0]   MS_PER_DAY    = 32'd86400000;

    // year / 25 by reciprocal, exact for 14-bit years
    localparam logic [12:0] DIV25_RECIP = 13'd5243;
    localparam int          DIV25_SHIFT = 17;
    localparam logic [4:0]  DIV25_CONST = 5'd25;

    // ring slots, in output order
    localparam int RING_COUNT = 5;
    localparam logic [2:0] RING_MONTH  = 3'd0;
    localparam logic [2:0] RING_DAY    = 3'd1;
    localparam logic [2:0] RING_HOUR   = 3'd2;
    localparam logic [2:0] RING_MINUTE = 3'd3;
    localparam logic [2:0] RING_SECOND = 3'd4;

    // month codes used by the month length function
    localparam logic [3:0] MONTH_NONE = 4'd0;
    localparam logic [3:0] MONTH_JAN  = 4'd1;
    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam logic [3:0] MONTH_DEC  = 4'd12;

    localparam logic [4:0] DAYS_LONG      = 5'd31;
    localparam logic [4:0] DAYS_FEB       = 5'd28;
    localparam logic [4:0] DAYS_FEB_LEAP  = 5'd29;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP_DATE,
        ST_PREP_MONTH,
        ST_PREP_YEAR,
        ST_LOAD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SLEW,
        ST_OUT
    } crfs_state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } crfs_div_stat_t;

    // days in the month, month zero counts as january, beyond december long
    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [3:0] m;
        logic [3:0] slot;
        m = (month == MONTH_NONE) ? MONTH_JAN : month;
        slot = m - MONTH_JAN;
        if (m > MONTH_DEC) begin
            return DAYS_LONG;
        end else if (m == MONTH_FEB) begin
            return leap ? DAYS_FEB_LEAP : DAYS_FEB;
        end else begin
            return MONTH_DAYS[slot];
        end
    endfunction

endpackage

>>> hw/rtl/crfs_div.sv
module crfs_div #(
    parameter int FRACTION_BITS = crfs_pkg::FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [crfs_pkg::NUM_W-1:0]    num,
    input  logic [crfs_pkg::NUM_W-1:0]    den,
    output crfs_pkg::crfs_div_stat_t      stat,
    output logic [FRACTION_BITS-1:0]      quot
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic [crfs_pkg::NUM_W-1:0] rem_reg;
    logic [crfs_pkg::NUM_W-1:0] den_reg;
    logic [FRACTION_BITS-1:0]   quot_reg;
    logic                       sat_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       done_reg;

    logic [crfs_pkg::NUM_W-1:0] rem_shift;
    logic                       rem_ge;
    logic [crfs_pkg::NUM_W-1:0] rem_next;
    logic                       busy;

    // one restoring step: shift, compare, subtract
    always_comb begin
        rem_shift = {rem_reg[crfs_pkg::NUM_W-2:0], 1'b0};
        rem_ge    = rem_shift >= den_reg;
        rem_next  = rem_ge ? (rem_shift - den_reg) : rem_shift;
        busy      = cnt_reg != '0;
    end

    // step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(FRACTION_BITS);
            done_reg <= 1'b0;
        end else if (busy) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= cnt_reg == CNT_W'(1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            den_reg  <= den;
            sat_reg  <= num >= den;
            quot_reg <= '0;
        end else if (busy) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[FRACTION_BITS-2:0], rem_ge};
        end
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign quot      = quot_reg;

endmodule

>>> hw/rtl/calendar_ring_fraction_slew.sv
// a word passes the prep states, then load, divide and slew per ring, then the output register
// no new input word is taken until the last one has moved into the output register
// the five fractions go one after another through a single radix-2 divider, one bit per cycle
// a finished word waits in the output register while the next input word is taken
// reset (aresetn, synchronous, active low): ring positions zero, slew_rate 131, no word pending
module calendar_ring_fraction_slew #(
    parameter int FRACTION_BITS = crfs_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_millisecond,
    input  logic [5:0]  s_second_count,
    input  logic [5:0]  s_minute_count,
    input  logic [4:0]  s_hour_count,
    input  logic [4:0]  s_day_of_month,
    input  logic [3:0]  s_month_number,
    input  logic [13:0] s_year_number,
    input  logic [9:0]  s_elapsed_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_month_ring_pos,
    output logic [15:0] m_day_ring_pos,
    output logic [15:0] m_hour_ring_pos,
    output logic [15:0] m_minute_ring_pos,
    output logic [15:0] m_second_ring_pos,
    output logic [4:0]  m_month_length
);

    localparam int CMP_W =
        ((FRACTION_BITS > crfs_pkg::STEP_W) ? FRACTION_BITS : crfs_pkg::STEP_W) + 1;
    localparam logic [FRACTION_BITS-1:0] FRAC_MAX = '1;
    localparam int NUM_W = crfs_pkg::NUM_W;

    crfs_pkg::crfs_state_t state_reg, state_next;

    logic [15:0] slew_reg;

    // latched input word
    logic [9:0]  ms_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic [4:0]  day_off_reg;
    logic [3:0]  month_reg;
    logic [3:0]  month_off_reg;
    logic [13:0] year_reg;
    logic [9:0]  yq_reg;
    logic [crfs_pkg::STEP_W-1:0] step_reg;

    // cascade terms
    logic [4:0]                       dim_reg;
    logic [crfs_pkg::TSEC_W-1:0]      t_sec_reg;
    logic [crfs_pkg::MIN_MS_W-1:0]    min_ms_reg;
    logic [crfs_pkg::HOUR_MS_W-1:0]   hour_ms_reg;
    logic [crfs_pkg::DAY_MS_W-1:0]    day_ms_reg;
    logic [crfs_pkg::MONTH_MS_W-1:0]  month_ms_reg;
    logic [NUM_W-1:0]                 year_off_reg;
    logic [NUM_W-1:0]                 year_len_reg;

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] den_reg;
    logic [NUM_W-1:0] offset_sel;
    logic [NUM_W-1:0] den_sel;

    logic [2:0] idx_reg;
    logic [FRACTION_BITS-1:0] pos_reg [crfs_pkg::RING_COUNT];

    logic [26:0] yq_prod;
    logic [14:0] y25_back;
    logic        div25;
    logic        leap;

    logic                         div_start;
    crfs_pkg::crfs_div_stat_t     div_stat;
    logic [FRACTION_BITS-1:0]     div_quot;

    logic [FRACTION_BITS-1:0] target;
    logic [CMP_W-1:0]         cur_w;
    logic [CMP_W-1:0]         tgt_w;
    logic [CMP_W-1:0]         stp_w;
    logic [CMP_W-1:0]         diff_w;
    logic [CMP_W-1:0]         moved_w;
    logic [FRACTION_BITS-1:0] pos_new;

    logic        out_load;
    logic        m_valid_reg;
    logic [15:0] out_pos_reg [crfs_pkg::RING_COUNT];
    logic [4:0]  out_dim_reg;

    // shared divider
    crfs_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            crfs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = crfs_pkg::ST_PREP_DATE;
                end
            end
            crfs_pkg::ST_PREP_DATE:  state_next = crfs_pkg::ST_PREP_MONTH;
            crfs_pkg::ST_PREP_MONTH: state_next = crfs_pkg::ST_PREP_YEAR;
            crfs_pkg::ST_PREP_YEAR:  state_next = crfs_pkg::ST_LOAD;
            crfs_pkg::ST_LOAD:       state_next = crfs_pkg::ST_DIV_START;
            crfs_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = crfs_pkg::ST_DIV_WAIT;
            end
            crfs_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = crfs_pkg::ST_SLEW;
                end
            end
            crfs_pkg::ST_SLEW: begin
                if (idx_reg == crfs_pkg::RING_MONTH) begin
                    state_next = crfs_pkg::ST_OUT;
                end else begin
                    state_next = crfs_pkg::ST_LOAD;
                end
            end
            crfs_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = crfs_pkg::ST_IDLE;
                end
            end
            default: state_next = crfs_pkg::ST_IDLE;
        endcase
    end

    assign s_ready = state_reg == crfs_pkg::ST_IDLE;

    // leap rule: divisible by 25 via reciprocal, 400 = 16 * 25
    always_comb begin
        yq_prod  = 27'(s_year_number) * 27'(crfs_pkg::DIV25_RECIP);
        y25_back = 15'(yq_reg) * 15'(crfs_pkg::DIV25_CONST);
        div25    = y25_back == {1'b0, year_reg};
        leap     = ((year_reg[1:0] == 2'b00) && !div25) ||
                   ((year_reg[3:0] == 4'b0000) && div25);
    end

    // offset and period for the ring in work
    always_comb begin
        case (idx_reg)
            crfs_pkg::RING_SECOND: begin
                offset_sel = NUM_W'(t_sec_reg);
                den_sel    = NUM_W'(crfs_pkg::MS_PER_MINUTE);
            end
            crfs_pkg::RING_MINUTE: begin
                offset_sel = NUM_W'(min_ms_reg);
                den_sel    = NUM_W'(crfs_pkg::MS_PER_HOUR);
            end
            crfs_pkg::RING_HOUR: begin
                offset_sel = NUM_W'(hour_ms_reg);
                den_sel    = NUM_W'(crfs_pkg::MS_PER_DAY);
            end
            crfs_pkg::RING_DAY: begin
                offset_sel = NUM_W'(day_ms_reg);
                den_sel    = NUM_W'(month_ms_reg);
            end
            crfs_pkg::RING_MONTH: begin
                offset_sel = year_off_reg;
                den_sel    = year_len_reg;
            end
            default: begin
                offset_sel = '0;
                den_sel    = '0;
            end
        endcase
    end

    // slew toward the fraction, snap when within one step
    always_comb begin
        target = div_stat.sat ? FRAC_MAX : div_quot;
        cur_w  = CMP_W'(pos_reg[idx_reg]);
        tgt_w  = CMP_W'(target);
        stp_w  = CMP_W'(step_reg);
        if (tgt_w >= cur_w) begin
            diff_w  = tgt_w - cur_w;
            moved_w = (diff_w <= stp_w) ? tgt_w : (cur_w + stp_w);
        end else begin
            diff_w  = cur_w - tgt_w;
            moved_w = (diff_w <= stp_w) ? tgt_w : (cur_w - stp_w);
        end
        pos_new = moved_w[FRACTION_BITS-1:0];
    end

    // control state, ring positions and the config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= crfs_pkg::ST_IDLE;
            idx_reg     <= crfs_pkg::RING_SECOND;
            m_valid_reg <= 1'b0;
            slew_reg    <= 16'd131;
            for (int i = 0; i < crfs_pkg::RING_COUNT; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                slew_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                idx_reg <= crfs_pkg::RING_SECOND;
            end
            if (state_reg == crfs_pkg::ST_SLEW) begin
                pos_reg[idx_reg] <= pos_new;
                if (idx_reg != crfs_pkg::RING_MONTH) begin
                    idx_reg <= idx_reg - 3'd1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input capture and cascade terms
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ms_reg        <= s_millisecond;
            sec_reg       <= s_second_count;
            min_reg       <= s_minute_count;
            hour_reg      <= s_hour_count;
            day_off_reg   <= (s_day_of_month == 5'd0) ? 5'd0 : (s_day_of_month - 5'd1);
            month_reg     <= s_month_number;
            month_off_reg <= (s_month_number == crfs_pkg::MONTH_NONE) ?
                             4'd0 : (s_month_number - 4'd1);
            year_reg      <= s_year_number;
            yq_reg        <= yq_prod[crfs_pkg::DIV25_SHIFT +: 10];
            step_reg      <= crfs_pkg::STEP_W'(slew_reg) * crfs_pkg::STEP_W'(s_elapsed_ms);
            num_reg       <= '0;
        end
        case (state_reg)
            crfs_pkg::ST_PREP_DATE: begin
                dim_reg     <= crfs_pkg::days_in_month(month_reg, leap);
                t_sec_reg   <= crfs_pkg::TSEC_W'(sec_reg) * crfs_pkg::MS_PER_SECOND +
                               crfs_pkg::TSEC_W'(ms_reg);
                min_ms_reg  <= crfs_pkg::MIN_MS_W'(min_reg) * crfs_pkg::MS_PER_MINUTE;
                hour_ms_reg <= crfs_pkg::HOUR_MS_W'(hour_reg) * crfs_pkg::MS_PER_HOUR;
                day_ms_reg  <= crfs_pkg::DAY_MS_W'(day_off_reg) * crfs_pkg::MS_PER_DAY;
            end
            crfs_pkg::ST_PREP_MONTH: begin
                month_ms_reg <= crfs_pkg::MONTH_MS_W'(dim_reg) * crfs_pkg::MS_PER_DAY;
            end
            crfs_pkg::ST_PREP_YEAR: begin
                year_off_reg <= NUM_W'(month_off_reg) * NUM_W'(month_ms_reg);
                year_len_reg <= (NUM_W'(month_ms_reg) << 3) + (NUM_W'(month_ms_reg) << 2);
            end
            crfs_pkg::ST_LOAD: begin
                num_reg <= num_reg + offset_sel;
                den_reg <= den_sel;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < crfs_pkg::RING_COUNT; i++) begin
                out_pos_reg[i] <= 16'(pos_reg[i]);
            end
            out_dim_reg <= dim_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_month_ring_pos  = out_pos_reg[crfs_pkg::RING_MONTH];
    assign m_day_ring_pos    = out_pos_reg[crfs_pkg::RING_DAY];
    assign m_hour_ring_pos   = out_pos_reg[crfs_pkg::RING_HOUR];
    assign m_minute_ring_pos = out_pos_reg[crfs_pkg::RING_MINUTE];
    assign m_second_ring_pos = out_pos_reg[crfs_pkg::RING_SECOND];
    assign m_month_length    = out_dim_reg;

endmodule

>>> hw/rtl/crfs_checker.sv
module crfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_month_ring_pos,
    input logic [4:0]  m_month_length
);

    // no second word is taken right after one is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken on back-to-back cycles");

    // a result only appears after the block stopped taking input
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without work in progress");

    // month length stays in the calendar range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month_length == 5'd28 || m_month_length == 5'd29 ||
                     m_month_length == 5'd30 || m_month_length == 5'd31))
        else $error("month length out of range");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_month_ring_pos) &&
                                   $stable(m_month_length)))
        else $error("stalled result word changed");

endmodule

bind calendar_ring_fraction_slew crfs_checker u_crfs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_month_ring_pos (m_month_ring_pos),
    .m_month_length   (m_month_length)
);

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int          FRAC_W        = 16;
    localparam logic [63:0] FRAC_MAX      = 64'h0000_0000_0000_FFFF;
    localparam int          LATENCY_CYCLES = 5 * (FRAC_W + 4) + 5;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [15:0] SLEW_DEFAULT  = 16'd131;

    // one time word going in
    typedef struct packed {
        logic [9:0]  millisecond;
        logic [5:0]  second_count;
        logic [5:0]  minute_count;
        logic [4:0]  hour_count;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [13:0] year_number;
        logic [9:0]  elapsed_ms;
    } clock_word_t;

    // one ring word coming out
    typedef struct packed {
        logic [15:0] month_pos;
        logic [15:0] day_pos;
        logic [15:0] hour_pos;
        logic [15:0] minute_pos;
        logic [15:0] second_pos;
        logic [4:0]  month_len;
    } ring_word_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [9:0]  s_millisecond;
    logic [5:0]  s_second_count;
    logic [5:0]  s_minute_count;
    logic [4:0]  s_hour_count;
    logic [4:0]  s_day_of_month;
    logic [3:0]  s_month_number;
    logic [13:0] s_year_number;
    logic [9:0]  s_elapsed_ms;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_month_ring_pos;
    logic [15:0] m_day_ring_pos;
    logic [15:0] m_hour_ring_pos;
    logic [15:0] m_minute_ring_pos;
    logic [15:0] m_second_ring_pos;
    logic [4:0]  m_month_length;

    // predictor state
    logic [63:0] ring_pos_model [crfs_pkg::RING_COUNT];
    logic [15:0] slew_rate_model;
    ring_word_t  expected_rings [$];

    // pacing and bookkeeping
    bit          pacing_on;
    int          burst_left;
    int          words_sent;
    int          rings_checked;
    int          slew_settings;
    int          fail_count;
    int          report_count;
    clock_word_t running;
    ring_word_t  exp_w;
    ring_word_t  got_w;

    calendar_ring_fraction_slew #(
        .FRACTION_BITS(FRAC_W)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_millisecond     (s_millisecond),
        .s_second_count    (s_second_count),
        .s_minute_count    (s_minute_count),
        .s_hour_count      (s_hour_count),
        .s_day_of_month    (s_day_of_month),
        .s_month_number    (s_month_number),
        .s_year_number     (s_year_number),
        .s_elapsed_ms      (s_elapsed_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_month_ring_pos  (m_month_ring_pos),
        .m_day_ring_pos    (m_day_ring_pos),
        .m_hour_ring_pos   (m_hour_ring_pos),
        .m_minute_ring_pos (m_minute_ring_pos),
        .m_second_ring_pos (m_second_ring_pos),
        .m_month_length    (m_month_length)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("** calendar_ring_fraction_slew: FAILED **");
        $finish;
    end

    // gregorian month length, month zero as january, beyond december long
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic [13:0] year);
        logic leap;
        leap = (((year % 4) == 0) && ((year % 100) != 0)) || ((year % 400) == 0);
        case (month)
            4'd2: begin
                return leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                return 5'd30;
            end
            default: begin
                return 5'd31;
            end
        endcase
    endfunction

    // truncated fixed-point ratio, saturating just below one
    function automatic logic [63:0] ring_fraction(input logic [63:0] part, input logic [63:0] period);
        logic [63:0] q;
        q = (part << FRAC_W) / period;
        return (q > FRAC_MAX) ? FRAC_MAX : q;
    endfunction

    // move by at most step, land on target when close enough
    function automatic logic [63:0] slew_toward(input logic [63:0] cur, input logic [63:0] target,
                                                input logic [63:0] step);
        if (target >= cur) begin
            return ((target - cur) <= step) ? target : cur + step;
        end else begin
            return ((cur - target) <= step) ? target : cur - step;
        end
    endfunction

    // expected ring word for one accepted time word, advances ring state
    function automatic ring_word_t predict_rings(input clock_word_t w);
        logic [63:0] dim;
        logic [63:0] day_off;
        logic [63:0] month_off;
        logic [63:0] t_sec;
        logic [63:0] t_min;
        logic [63:0] t_hour;
        logic [63:0] t_day;
        logic [63:0] month_ms;
        logic [63:0] t_year;
        logic [63:0] step;
        logic [63:0] target [crfs_pkg::RING_COUNT];
        ring_word_t  r;
        dim       = month_days(w.month_number, w.year_number);
        day_off   = (w.day_of_month == 5'd0) ? 64'd0 : w.day_of_month - 64'd1;
        month_off = (w.month_number == 4'd0) ? 64'd0 : w.month_number - 64'd1;
        t_sec     = w.second_count * 64'd1000 + w.millisecond;
        t_min     = w.minute_count * 64'd60000 + t_sec;
        t_hour    = w.hour_count * 64'd3600000 + t_min;
        t_day     = day_off * 64'd86400000 + t_hour;
        month_ms  = dim * 64'd86400000;
        t_year    = month_off * month_ms + t_day;
        step      = slew_rate_model * w.elapsed_ms;
        target[crfs_pkg::RING_MONTH]  = ring_fraction(t_year, 64'd12 * month_ms);
        target[crfs_pkg::RING_DAY]    = ring_fraction(t_day, month_ms);
        target[crfs_pkg::RING_HOUR]   = ring_fraction(t_hour, 64'd86400000);
        target[crfs_pkg::RING_MINUTE] = ring_fraction(t_min, 64'd3600000);
        target[crfs_pkg::RING_SECOND] = ring_fraction(t_sec, 64'd60000);
        for (int i = 0; i < crfs_pkg::RING_COUNT; i++) begin
            ring_pos_model[i] = slew_toward(ring_pos_model[i], target[i], step) & FRAC_MAX;
        end
        r.month_pos  = ring_pos_model[crfs_pkg::RING_MONTH][15:0];
        r.day_pos    = ring_pos_model[crfs_pkg::RING_DAY][15:0];
        r.hour_pos   = ring_pos_model[crfs_pkg::RING_HOUR][15:0];
        r.minute_pos = ring_pos_model[crfs_pkg::RING_MINUTE][15:0];
        r.second_pos = ring_pos_model[crfs_pkg::RING_SECOND][15:0];
        r.month_len  = dim[4:0];
        return r;
    endfunction

    function automatic clock_word_t make_word(input int ms, input int sec, input int mn,
                                              input int hr, input int dy, input int mo,
                                              input int yr, input int el);
        clock_word_t w;
        w.millisecond  = 10'(ms);
        w.second_count = 6'(sec);
        w.minute_count = 6'(mn);
        w.hour_count   = 5'(hr);
        w.day_of_month = 5'(dy);
        w.month_number = 4'(mo);
        w.year_number  = 14'(yr);
        w.elapsed_ms   = 10'(el);
        return w;
    endfunction

    // frame time: mostly display-like, sometimes zero or long, rarely past range
    function automatic int pick_elapsed();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) begin
            return 0;
        end else if (k < 3) begin
            return $urandom_range(0, 1000);
        end else if (k == 3) begin
            return $urandom_range(1001, 1023);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic clock_word_t random_date_word();
        clock_word_t w;
        w.year_number  = 14'($urandom_range(0, 9999));
        w.month_number = 4'($urandom_range(1, 12));
        w.day_of_month = 5'($urandom_range(1, month_days(w.month_number, w.year_number)));
        w.hour_count   = 5'($urandom_range(0, 23));
        w.minute_count = 6'($urandom_range(0, 59));
        w.second_count = 6'($urandom_range(0, 59));
        w.millisecond  = 10'($urandom_range(0, 999));
        w.elapsed_ms   = 10'(pick_elapsed());
        return w;
    endfunction

    function automatic clock_word_t noise_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[59:0];
    endfunction

    // advance a well-formed local time by one frame
    function automatic clock_word_t tick_clock(input clock_word_t w, input int el);
        int ms;
        int sec;
        int mn;
        int hr;
        int dy;
        int mo;
        int yr;
        ms  = w.millisecond + el;
        sec = w.second_count + ms / 1000;
        ms  = ms % 1000;
        mn  = w.minute_count + sec / 60;
        sec = sec % 60;
        hr  = w.hour_count + mn / 60;
        mn  = mn % 60;
        dy  = w.day_of_month + hr / 24;
        hr  = hr % 24;
        mo  = w.month_number;
        yr  = w.year_number;
        if (dy > month_days(4'(mo), 14'(yr))) begin
            dy = 1;
            mo = mo + 1;
            if (mo > 12) begin
                mo = 1;
                yr = (yr + 1) % 10000;
            end
        end
        return make_word(ms, sec, mn, hr, dy, mo, yr, el);
    endfunction

    // send one word, with random burst gaps when pacing is on
    task automatic send_word(input clock_word_t w);
        int gap;
        if (pacing_on && burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 20);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge aclk);
        s_millisecond  = w.millisecond;
        s_second_count = w.second_count;
        s_minute_count = w.minute_count;
        s_hour_count   = w.hour_count;
        s_day_of_month = w.day_of_month;
        s_month_number = w.month_number;
        s_year_number  = w.year_number;
        s_elapsed_ms   = w.elapsed_ms;
        s_valid        = 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_rings.push_back(predict_rings(w));
        words_sent++;
    endtask

    // wait until every expected ring word is back, plus a short settle
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_rings.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // slew rate write, only with the block idle
    task automatic set_slew_rate(input logic [15:0] rate);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = rate;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        slew_rate_model = rate;
        slew_settings++;
    endtask

    // receiver: long ready stretches, random chatter, and held stalls
    initial begin
        int mode;
        int hi_len;
        int lo_len;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            if (mode == 0) begin
                @(negedge aclk);
                m_ready = 1'b1;
                repeat ($urandom_range(300, 1500)) @(negedge aclk);
            end else if (mode == 1) begin
                repeat (200) begin
                    @(negedge aclk);
                    m_ready = 1'($urandom_range(0, 1));
                end
            end else begin
                lo_len = $urandom_range(1, 60);
                hi_len = $urandom_range(1, 120);
                @(negedge aclk);
                m_ready = 1'b0;
                repeat (lo_len - 1) @(negedge aclk);
                @(negedge aclk);
                m_ready = 1'b1;
                repeat (hi_len - 1) @(negedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_w = {m_month_ring_pos, m_day_ring_pos, m_hour_ring_pos,
                     m_minute_ring_pos, m_second_ring_pos, m_month_length};
            if (expected_rings.size() == 0) begin
                fail_count++;
                if (report_count < REPORT_LIMIT) begin
                    report_count++;
                    $display("unexpected ring word at %0t: %h", $realtime, got_w);
                end
            end else begin
                exp_w = expected_rings.pop_front();
                rings_checked++;
                if (got_w.month_pos  !== exp_w.month_pos  || got_w.day_pos    !== exp_w.day_pos ||
                    got_w.hour_pos   !== exp_w.hour_pos   || got_w.minute_pos !== exp_w.minute_pos ||
                    got_w.second_pos !== exp_w.second_pos || got_w.month_len  !== exp_w.month_len) begin
                    fail_count++;
                    if (report_count < REPORT_LIMIT) begin
                        report_count++;
                        $display("mismatch on word %0d at %0t", rings_checked, $realtime);
                        $display("  month %h/%h day %h/%h hour %h/%h (exp/act)",
                                 exp_w.month_pos, got_w.month_pos, exp_w.day_pos, got_w.day_pos,
                                 exp_w.hour_pos, got_w.hour_pos);
                        $display("  minute %h/%h second %h/%h month_len %0d/%0d (exp/act)",
                                 exp_w.minute_pos, got_w.minute_pos,
                                 exp_w.second_pos, got_w.second_pos,
                                 exp_w.month_len, got_w.month_len);
                    end
                end
            end
        end
    end

    // reset value of the slew rate, zero elapsed keeps rings still
    task automatic test_reset_state();
        send_word(make_word(0, 0, 0, 0, 1, 1, 2024, 0));
        send_word(make_word(500, 30, 30, 12, 15, 6, 2024, 16));
        send_word(make_word(500, 30, 30, 12, 15, 6, 2024, 16));
        drain_results();
    endtask

    // field extremes, in range and full width
    task automatic test_field_extremes();
        set_slew_rate(16'd4000);
        send_word(make_word(999, 59, 59, 23, 31, 12, 9999, 1000));
        send_word(make_word(0, 0, 0, 0, 1, 1, 0, 1000));
        send_word(make_word(1023, 63, 63, 31, 31, 15, 16383, 1023));
        // day zero counts as day one, month zero as january
        send_word(make_word(250, 10, 20, 5, 0, 0, 2001, 500));
        // month past december: long month, year fraction saturates
        send_word(make_word(250, 10, 20, 5, 10, 13, 2001, 500));
        send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0));
        drain_results();
    endtask

    // leap rule on february, and day past month end saturating
    task automatic test_leap_rule();
        set_slew_rate(16'hFFFF);
        send_word(make_word(0, 0, 0, 12, 29, 2, 2000, 100));
        send_word(make_word(0, 0, 0, 12, 28, 2, 1900, 100));
        send_word(make_word(0, 0, 0, 12, 29, 2, 2024, 100));
        send_word(make_word(0, 0, 0, 12, 28, 2, 2023, 100));
        send_word(make_word(0, 0, 0, 12, 29, 2, 0, 100));
        send_word(make_word(0, 0, 0, 12, 31, 2, 2023, 100));
        send_word(make_word(999, 59, 59, 23, 31, 12, 9999, 100));
        drain_results();
    endtask

    // slew rate zero, one and 1000
    task automatic test_slew_limits();
        set_slew_rate(16'd0);
        send_word(make_word(0, 0, 0, 0, 1, 1, 2020, 1023));
        send_word(make_word(999, 59, 59, 23, 31, 12, 2020, 1000));
        set_slew_rate(16'd1);
        send_word(make_word(999, 59, 59, 23, 31, 12, 2020, 1));
        send_word(make_word(0, 0, 0, 0, 1, 1, 2020, 1000));
        set_slew_rate(16'd1000);
        send_word(make_word(123, 45, 6, 7, 8, 9, 1999, 16));
        send_word(make_word(123, 45, 6, 7, 8, 9, 1999, 33));
    endtask

    // random phases: mostly running-clock sequences, some jumps and noise
    task automatic test_random_calendar();
        logic [15:0] rates [6];
        int          per_phase;
        int          sent_in_phase;
        int          kind;
        int          run_len;
        rates[0]  = SLEW_DEFAULT;
        rates[1]  = 16'($urandom_range(1, 65535));
        rates[2]  = 16'd1;
        rates[3]  = 16'hFFFF;
        rates[4]  = 16'd0;
        rates[5]  = 16'($urandom_range(1, 400));
        per_phase = 85;
        running   = random_date_word();
        for (int p = 0; p < 6; p++) begin
            set_slew_rate(rates[p]);
            pacing_on     = (p != 0);
            burst_left    = 0;
            sent_in_phase = 0;
            while (sent_in_phase < per_phase) begin
                kind = $urandom_range(0, 19);
                if (kind < 15) begin
                    if (kind < 3) begin
                        running = random_date_word();
                    end
                    run_len = $urandom_range(5, 40);
                    if (run_len > per_phase - sent_in_phase) begin
                        run_len = per_phase - sent_in_phase;
                    end
                    repeat (run_len) begin
                        running = tick_clock(running, pick_elapsed());
                        send_word(running);
                        sent_in_phase++;
                    end
                end else if (kind < 18) begin
                    send_word(random_date_word());
                    sent_in_phase++;
                end else begin
                    send_word(noise_word());
                    sent_in_phase++;
                end
            end
        end
    endtask

    // main sequence
    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_millisecond  = '0;
        s_second_count = '0;
        s_minute_count = '0;
        s_hour_count   = '0;
        s_day_of_month = '0;
        s_month_number = '0;
        s_year_number  = '0;
        s_elapsed_ms   = '0;
        pacing_on      = 1'b0;
        burst_left     = 0;
        words_sent     = 0;
        rings_checked  = 0;
        slew_settings  = 1;
        fail_count     = 0;
        report_count   = 0;
        slew_rate_model = SLEW_DEFAULT;
        for (int i = 0; i < crfs_pkg::RING_COUNT; i++) begin
            ring_pos_model[i] = '0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_field_extremes();
        test_leap_rule();
        test_slew_limits();
        test_random_calendar();

        drain_results();
        repeat (LATENCY_CYCLES) @(posedge aclk);
        if (expected_rings.size() != 0) begin
            fail_count++;
            $display("%0d ring words never arrived", expected_rings.size());
        end
        $display("covered %0d time words and %0d ring words over %0d slew rate settings,",
                 words_sent, rings_checked, slew_settings);
        $display("including leap years, field extremes and out-of-range dates; %0d failures",
                 fail_count);
        if (fail_count == 0) begin
            $display("** calendar_ring_fraction_slew: PASSED **");
        end else begin
            $display("** calendar_ring_fraction_slew: FAILED **");
        end
        $finish;
    end

endmodule
